// ===== hdl/tkn_pkg.sv =====
// Shared types and constants for the top-k nearest candidate list.
`default_nettype none
package tkn_pkg;

    // List geometry.
    localparam int K_MAX  = 16;
    localparam int IDX_W  = $clog2(K_MAX);
    localparam int CNT_W  = $clog2(K_MAX + 1);
    localparam int KEEP_W = 5;
    localparam int RANK_W = 4;

    // Reset and clear value of the worst bound: largest positive Q16.16.
    localparam logic signed [31:0] WORST_RESET = 32'sh7FFF_FFFF;

    // Reset value of the keep count register.
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    // Item actions.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_READ  = 2'd2,
        ACT_IGNORE = 2'd3
    } t_action;

    // One input item.
    typedef struct packed {
        t_action            action;
        logic [31:0]        cand_id;
        logic signed [31:0] cand_distance;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                accepted;
        logic [4:0]          list_count;
        logic signed [31:0]  worst_bound;
        logic [RANK_W-1:0]   entry_rank;
        logic [31:0]         entry_id;
        logic signed [31:0]  entry_distance;
        logic                entry_valid;
        logic                last;
    } t_out_item;

    // One list entry held in a cell.
    typedef struct packed {
        logic [31:0]        id;
        logic signed [31:0] distance;
    } t_entry;

    // Per-cell control from the list controller.
    typedef struct packed {
        logic write;       // an offer enters the list this cycle
        logic below_slot;  // cell index is below the insertion slot
        logic at_slot;     // cell index is the insertion slot
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hdl/tkn_cell.sv =====
// One compare-and-shift cell of the sorted candidate list.
`default_nettype none
module tkn_cell (
    input  wire logic              i_clk,
    input  wire tkn_pkg::t_cell_ctl i_ctl,
    input  wire tkn_pkg::t_entry    i_cand,
    input  wire tkn_pkg::t_entry    i_left,
    input  wire logic              i_left_moves,
    output tkn_pkg::t_entry         o_entry,
    output logic                   o_moves
);

    tkn_pkg::t_entry r_entry;

    // This cell changes when it is the slot, or when it sits below the slot
    // and holds a strictly larger distance than the candidate.
    assign o_moves = i_ctl.at_slot ||
                     (i_ctl.below_slot &&
                      ($signed(r_entry.distance) > $signed(i_cand.distance)));

    // A changing cell takes the left neighbor's entry when that one moves too,
    // and otherwise the candidate itself.
    always_ff @(posedge i_clk) begin
        if (i_ctl.write && o_moves) begin
            r_entry <= i_left_moves ? i_left : i_cand;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== hdl/top_k_nearest_list.sv =====
// Top level of the top-k nearest candidate list: controller, cell row, output.
// Clear and offer items: one result one cycle after the item, next item any cycle.
// Readout: n entries (one result if empty), one per cycle, the first later than a status
// result by the readout sequencer register; busy is high while the sequencer walks them.
// An offer is absorbed by the cell row in the cycle it is taken.
// Synchronous active-low reset empties the list, sets the bound to its maximum
// and keep_count to 16; the receiver cannot stall, so results are never held.
`default_nettype none
module top_k_nearest_list (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire tkn_pkg::t_in_item               i_item,
    output logic                                 o_result_valid,
    output tkn_pkg::t_out_item                   o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [tkn_pkg::KEEP_W-1:0]      i_cfg_data
);

    localparam int K     = tkn_pkg::K_MAX;
    localparam int IDX_W = tkn_pkg::IDX_W;
    localparam int CNT_W = tkn_pkg::CNT_W;

    logic [tkn_pkg::KEEP_W-1:0] r_keep;
    logic [CNT_W-1:0]           r_held;
    logic [CNT_W-1:0]           n_held;
    logic signed [31:0]         r_worst;
    logic signed [31:0]         n_worst;
    logic                       r_rd_active;
    logic [IDX_W-1:0]           r_rd_idx;
    logic                       r_out_valid;
    tkn_pkg::t_out_item         r_out;

    logic [CNT_W-1:0]   w_eff_k;
    logic               w_take;
    logic               w_offer_ok;
    logic [IDX_W-1:0]   w_slot;
    tkn_pkg::t_entry    w_cand;
    tkn_pkg::t_entry    w_cells [K];
    logic               w_moves [K];
    logic               w_rd_last;

    assign w_take = start && !busy;
    assign w_cand = '{id: i_item.cand_id, distance: i_item.cand_distance};

    // Effective k: zero acts as one, anything above the list depth as the depth.
    always_comb begin
        if (r_keep == '0) begin
            w_eff_k = CNT_W'(1);
        end else if (CNT_W'(r_keep) > CNT_W'(K)) begin
            w_eff_k = CNT_W'(K);
        end else begin
            w_eff_k = CNT_W'(r_keep);
        end
    end

    // Insertion slot: append while not full, else replace the last entry when
    // the candidate beats the worst bound.
    always_comb begin
        w_offer_ok = 1'b0;
        w_slot     = '0;
        n_held     = r_held;
        if (w_take && (i_item.action == tkn_pkg::ACT_OFFER)) begin
            if (r_held < w_eff_k) begin
                w_offer_ok = 1'b1;
                w_slot     = r_held[IDX_W-1:0];
                n_held     = r_held + CNT_W'(1);
            end else if ((r_held != '0) &&
                         ($signed(i_item.cand_distance) < $signed(r_worst))) begin
                w_offer_ok = 1'b1;
                w_slot     = IDX_W'(r_held - CNT_W'(1));
            end
        end else if (w_take && (i_item.action == tkn_pkg::ACT_CLEAR)) begin
            n_held = '0;
        end
    end

    // Row of cells, each handing its entry to the right neighbor on insert.
    for (genvar g = 0; g < K; g++) begin : g_cell
        tkn_pkg::t_cell_ctl w_ctl;
        tkn_pkg::t_entry    w_left;
        logic               w_left_moves;

        assign w_ctl.write      = w_offer_ok;
        assign w_ctl.below_slot = (IDX_W'(g) < w_slot);
        assign w_ctl.at_slot    = (IDX_W'(g) == w_slot);

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_moves = 1'b0;
        end else begin : g_rest
            assign w_left       = w_cells[g-1];
            assign w_left_moves = w_moves[g-1];
        end

        tkn_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_cand       (w_cand),
            .i_left       (w_left),
            .i_left_moves (w_left_moves),
            .o_entry      (w_cells[g]),
            .o_moves      (w_moves[g])
        );
    end

    // Worst bound after the item. The new last entry is the candidate unless
    // the entry left of the slot shifts into it.
    always_comb begin
        n_worst = r_worst;
        if (w_take && (i_item.action == tkn_pkg::ACT_CLEAR)) begin
            n_worst = tkn_pkg::WORST_RESET;
        end else if (w_offer_ok && (n_held >= w_eff_k)) begin
            if ((w_slot != '0) && w_moves[w_slot - IDX_W'(1)]) begin
                n_worst = w_cells[w_slot - IDX_W'(1)].distance;
            end else begin
                n_worst = i_item.cand_distance;
            end
        end
    end

    // List state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep  <= tkn_pkg::KEEP_RESET;
            r_held  <= '0;
            r_worst <= tkn_pkg::WORST_RESET;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
            r_held  <= n_held;
            r_worst <= n_worst;
        end
    end

    assign w_rd_last = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_held);

    // Readout sequencer: walks the entries in rank order, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_active <= 1'b0;
            r_rd_idx    <= '0;
        end else if (r_rd_active) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
            if (w_rd_last) begin
                r_rd_active <= 1'b0;
            end
        end else if (w_take && (i_item.action == tkn_pkg::ACT_READ) && (r_held != '0)) begin
            r_rd_active <= 1'b1;
            r_rd_idx    <= '0;
        end
    end

    assign busy = r_rd_active;

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_rd_active ||
                           (w_take && !((i_item.action == tkn_pkg::ACT_READ) &&
                                        (r_held != '0)));
        end
    end

    // Result payload: one list entry during readout, else a status item.
    always_ff @(posedge i_clk) begin
        if (r_rd_active) begin
            r_out.accepted       <= 1'b0;
            r_out.list_count     <= 5'(r_held);
            r_out.worst_bound    <= r_worst;
            r_out.entry_rank     <= tkn_pkg::RANK_W'(r_rd_idx);
            r_out.entry_id       <= w_cells[r_rd_idx].id;
            r_out.entry_distance <= w_cells[r_rd_idx].distance;
            r_out.entry_valid    <= 1'b1;
            r_out.last           <= w_rd_last;
        end else begin
            r_out.accepted       <= w_offer_ok;
            r_out.list_count     <= 5'(n_held);
            r_out.worst_bound    <= n_worst;
            r_out.entry_rank     <= '0;
            r_out.entry_id       <= '0;
            r_out.entry_distance <= '0;
            r_out.entry_valid    <= 1'b0;
            r_out.last           <= 1'b1;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // The count never passes the list depth.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(K))
        else $error("held count exceeds list depth");

    // An accepted mark follows only an offer taken in the cycle before.
    a_accept_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.accepted) |->
        $past(w_take && (i_item.action == tkn_pkg::ACT_OFFER)))
        else $error("accepted mark without a taken offer");

    // A readout ends with its last entry on the result ports.
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_rd_active) |-> (o_result_valid && o_result.last && o_result.entry_valid))
        else $error("readout ended without a last entry");

    // Entries are only shown while the list holds some.
    a_entry_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.entry_valid) |-> (r_held != '0))
        else $error("entry shown from an empty list");

endmodule
`default_nettype wire
